// ----- rtl/lpec_pkg.sv -----
// Types, codes and constant tables shared by the LED pixel effect compositor.
`timescale 1ns / 1ps
package lpec_pkg;

  localparam int unsigned MAX_COLUMNS     = 64;
  localparam int unsigned WAVE_TABLE_SIZE = 256;

  localparam logic [6:0]  MAX_COLUMNS_W    = 7'(MAX_COLUMNS);
  localparam logic [16:0] BLINK_FULL_SCALE = 17'd65471;
  localparam logic [4:0]  PIX_DIV_LAST     = 5'd19;
  localparam logic [4:0]  TICK_DIV_LAST    = 5'd11;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_SET   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_COLUMN_COUNT   = 3'd0,
    CFG_CENTER_COLUMNS = 3'd1,
    CFG_SIDE_COLUMNS   = 3'd2,
    CFG_STROBE_PERIOD  = 3'd3,
    CFG_BLINK_PERIOD   = 3'd4,
    CFG_BLINK_FLOOR    = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ZONE_LEFT   = 2'd0,
    ZONE_CENTER = 2'd1,
    ZONE_RIGHT  = 2'd2,
    ZONE_NONE   = 2'd3
  } zone_t;

  typedef enum logic [1:0] {
    EFF_NONE   = 2'd0,
    EFF_BLINK  = 2'd1,
    EFF_STROBE = 2'd2
  } eff_t;

  // phase slots: strobe, then the three blink zones
  typedef enum logic [1:0] {
    PH_STROBE = 2'd0,
    PH_LEFT   = 2'd1,
    PH_CENTER = 2'd2,
    PH_RIGHT  = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_BLEND,
    ST_EVAL,
    ST_PDIV,
    ST_LUT,
    ST_SCALE,
    ST_APPLY,
    ST_OUT,
    ST_TCHK,
    ST_TDIV,
    ST_TUPD,
    ST_SET
  } state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] from_red;
    logic [7:0] from_green;
    logic [7:0] from_blue;
    logic [7:0] to_red;
    logic [7:0] to_green;
    logic [7:0] to_blue;
    logic [5:0] visual_column;
    logic [8:0] fade_progress;
    logic       strobe_request;
    logic [2:0] blink_request;
  } in_item_t;

  typedef struct packed {
    logic [7:0] shown_red;
    logic [7:0] shown_green;
    logic [7:0] shown_blue;
    logic [7:0] kept_red;
    logic [7:0] kept_green;
    logic [7:0] kept_blue;
  } out_item_t;

  typedef struct packed {
    logic   load_in;
    logic   blend_load;
    logic   div_load;
    logic   div_tick;
    phase_t tick_sel;
    logic   div_step;
    logic   lut_load;
    logic   scale_load;
    logic   apply_load;
    logic   out_load;
    logic   tick_update;
    logic   set_update;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    eff_t       eff;
    logic [3:0] tick_act;
  } dp_stat_t;

  typedef logic [8:0] wave_lut_t [WAVE_TABLE_SIZE];

  // shift-subtract quotient, evaluated at elaboration only
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q8 strobe wave for one step, evaluated at elaboration only
  function automatic logic [8:0] wave_entry(longint unsigned k);
    longint unsigned n;
    longint unsigned prod;
    longint unsigned num;
    longint unsigned den;
    longint unsigned s;
    n    = longint'(WAVE_TABLE_SIZE);
    prod = k * (n - k);
    num  = (64'd16 * prod) << 16;
    den  = 64'd5 * n * n - 64'd4 * prod;
    s    = udiv(num, den);
    if (s > 64'd65536) s = 64'd65536;
    return 9'((s * s + (64'd1 << 23)) >> 24);
  endfunction

  function automatic wave_lut_t build_wave_lut();
    wave_lut_t lut;
    for (int i = 0; i < WAVE_TABLE_SIZE; i++) begin
      lut[i] = wave_entry(longint'(i));
    end
    return lut;
  endfunction

  localparam wave_lut_t WAVE_LUT = build_wave_lut();

endpackage

// ----- rtl/lpec_in_if.sv -----
// Input channel: valid/ready handshake carrying one command item.
`timescale 1ns / 1ps
interface lpec_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] from_red;
  logic [7:0] from_green;
  logic [7:0] from_blue;
  logic [7:0] to_red;
  logic [7:0] to_green;
  logic [7:0] to_blue;
  logic [5:0] visual_column;
  logic [8:0] fade_progress;
  logic       strobe_request;
  logic [2:0] blink_request;

  modport source (
    output valid, command, from_red, from_green, from_blue, to_red, to_green, to_blue,
           visual_column, fade_progress, strobe_request, blink_request,
    input  ready
  );
  modport sink (
    input  valid, command, from_red, from_green, from_blue, to_red, to_green, to_blue,
           visual_column, fade_progress, strobe_request, blink_request,
    output ready
  );
endinterface

// ----- rtl/lpec_out_if.sv -----
// Result channel: valid/ready handshake carrying the shown and kept colors.
`timescale 1ns / 1ps
interface lpec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] shown_red;
  logic [7:0] shown_green;
  logic [7:0] shown_blue;
  logic [7:0] kept_red;
  logic [7:0] kept_green;
  logic [7:0] kept_blue;

  modport source (
    output valid, shown_red, shown_green, shown_blue, kept_red, kept_green, kept_blue,
    input  ready
  );
  modport sink (
    input  valid, shown_red, shown_green, shown_blue, kept_red, kept_green, kept_blue,
    output ready
  );
endinterface

// ----- rtl/lpec_dpath.sv -----
// Datapath: config, effect state, blends, zone map, phase divider and scaling.
`timescale 1ns / 1ps
module lpec_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [11:0]         cfg_data,
  input  lpec_pkg::in_item_t  in_item,
  input  lpec_pkg::dp_cmd_t   cmd,
  output lpec_pkg::dp_stat_t  stat,
  output lpec_pkg::out_item_t out_item
);

  function automatic logic [7:0] blend8(logic [7:0] a, logic [7:0] b, logic [8:0] w);
    logic signed [18:0] v;
    v = $signed({3'b000, a, 8'h00})
      + ($signed({1'b0, b}) - $signed({1'b0, a})) * $signed({1'b0, w});
    return v[15:8];
  endfunction

  // configuration registers
  logic [6:0]  col_cnt_r, ctr_cols_r, side_cols_r;
  logic [11:0] strobe_per_r, blink_per_r;
  logic [8:0]  floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r    <= 7'd32;
      ctr_cols_r   <= 7'd3;
      side_cols_r  <= 7'd12;
      strobe_per_r <= 12'd800;
      blink_per_r  <= 12'd2500;
      floor_r      <= 9'd26;
    end else if (cfg_we) begin
      case (cfg_index)
        lpec_pkg::CFG_COLUMN_COUNT:   col_cnt_r    <= cfg_data[6:0];
        lpec_pkg::CFG_CENTER_COLUMNS: ctr_cols_r   <= cfg_data[6:0];
        lpec_pkg::CFG_SIDE_COLUMNS:   side_cols_r  <= cfg_data[6:0];
        lpec_pkg::CFG_STROBE_PERIOD:  strobe_per_r <= cfg_data;
        lpec_pkg::CFG_BLINK_PERIOD:   blink_per_r  <= cfg_data;
        lpec_pkg::CFG_BLINK_FLOOR:    floor_r      <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // captured transaction
  lpec_pkg::in_item_t item_r;
  always_ff @(posedge clk) begin
    if (cmd.load_in) item_r <= in_item;
  end

  // fade blend and zone map
  logic [8:0] prog;
  logic [6:0] cc, cw, sw, v;
  logic [5:0] cs;
  logic [7:0] cend;
  lpec_pkg::zone_t zone_c, zone_r;
  logic [7:0] kept_r [3];
  logic [7:0] shown_r [3];

  assign prog = (item_r.fade_progress > 9'd256) ? 9'd256 : item_r.fade_progress;
  assign cc   = (col_cnt_r > lpec_pkg::MAX_COLUMNS_W) ? lpec_pkg::MAX_COLUMNS_W : col_cnt_r;
  assign cw   = (ctr_cols_r < cc) ? ctr_cols_r : cc;
  assign sw   = (side_cols_r < cc) ? side_cols_r : cc;
  assign cs   = 6'((cc - cw) >> 1);
  assign cend = {2'b00, cs} + {1'b0, cw};
  assign v    = {1'b0, item_r.visual_column};

  always_comb begin
    if (v >= cc) zone_c = lpec_pkg::ZONE_NONE;
    else if (v >= {1'b0, cs} && {1'b0, v} < cend) zone_c = lpec_pkg::ZONE_CENTER;
    else if (v >= cc - sw) zone_c = lpec_pkg::ZONE_LEFT;
    else if (v < sw) zone_c = lpec_pkg::ZONE_RIGHT;
    else zone_c = lpec_pkg::ZONE_NONE;
  end

  always_ff @(posedge clk) begin
    if (cmd.blend_load) begin
      kept_r[0] <= blend8(item_r.from_red, item_r.to_red, prog);
      kept_r[1] <= blend8(item_r.from_green, item_r.to_green, prog);
      kept_r[2] <= blend8(item_r.from_blue, item_r.to_blue, prog);
      zone_r    <= zone_c;
    end
  end

  // effect state
  logic        strobe_on_r;
  logic [11:0] strobe_time_r;
  logic [2:0]  blink_on_r;
  logic [11:0] blink_time_r [3];

  logic lit;
  lpec_pkg::eff_t eff;
  assign lit = |{kept_r[0], kept_r[1], kept_r[2]};
  always_comb begin
    if (strobe_on_r) eff = lpec_pkg::EFF_STROBE;
    else if (zone_r != lpec_pkg::ZONE_NONE && blink_on_r[zone_r] && lit)
      eff = lpec_pkg::EFF_BLINK;
    else eff = lpec_pkg::EFF_NONE;
  end

  assign stat.command  = item_r.command;
  assign stat.eff      = eff;
  assign stat.tick_act = {blink_on_r, strobe_on_r};

  // phase divider: quotient of {t, 8'h00} / p, remainder once all 12 bits of t are shifted in is t mod p
  lpec_pkg::phase_t ph_c, ph_r;
  logic [11:0] src_t, src_p;
  logic [11:0] per_r, rem_r;
  logic [19:0] dvd_r;
  logic [7:0]  quo_r;
  logic [12:0] rem_sh, rem_sub;
  logic        ge;

  always_comb begin
    if (cmd.div_tick) ph_c = cmd.tick_sel;
    else if (eff == lpec_pkg::EFF_STROBE) ph_c = lpec_pkg::PH_STROBE;
    else begin
      case (zone_r)
        lpec_pkg::ZONE_LEFT:   ph_c = lpec_pkg::PH_LEFT;
        lpec_pkg::ZONE_CENTER: ph_c = lpec_pkg::PH_CENTER;
        default:               ph_c = lpec_pkg::PH_RIGHT;
      endcase
    end
    case (ph_c)
      lpec_pkg::PH_STROBE: begin src_t = strobe_time_r;   src_p = strobe_per_r; end
      lpec_pkg::PH_LEFT:   begin src_t = blink_time_r[0]; src_p = blink_per_r; end
      lpec_pkg::PH_CENTER: begin src_t = blink_time_r[1]; src_p = blink_per_r; end
      default:             begin src_t = blink_time_r[2]; src_p = blink_per_r; end
    endcase
  end

  assign rem_sh  = {rem_r, dvd_r[19]};
  assign ge      = rem_sh >= {1'b0, per_r};
  assign rem_sub = rem_sh - {1'b0, per_r};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      ph_r  <= ph_c;
      per_r <= (src_p == 12'd0) ? 12'd1 : src_p;
      dvd_r <= {src_t, 8'h00};
      rem_r <= 12'd0;
      quo_r <= 8'd0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[18:0], 1'b0};
      rem_r <= ge ? rem_sub[11:0] : rem_sh[11:0];
      quo_r <= {quo_r[6:0], ge};
    end
  end

  // tick advance and effect enables
  logic [12:0] t_inc;
  logic [11:0] t_new;
  assign t_inc = {1'b0, rem_r} + 13'd1;
  assign t_new = (t_inc >= {1'b0, per_r}) ? 12'd0 : t_inc[11:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_on_r   <= 1'b0;
      strobe_time_r <= 12'd0;
      blink_on_r    <= 3'b000;
      for (int i = 0; i < 3; i++) blink_time_r[i] <= 12'd0;
    end else if (cmd.tick_update) begin
      case (ph_r)
        lpec_pkg::PH_STROBE: strobe_time_r   <= t_new;
        lpec_pkg::PH_LEFT:   blink_time_r[0] <= t_new;
        lpec_pkg::PH_CENTER: blink_time_r[1] <= t_new;
        default:             blink_time_r[2] <= t_new;
      endcase
    end else if (cmd.set_update) begin
      strobe_on_r <= item_r.strobe_request;
      if (!item_r.strobe_request || !strobe_on_r) strobe_time_r <= 12'd0;
      blink_on_r <= item_r.blink_request;
      for (int i = 0; i < 3; i++) begin
        if (!item_r.blink_request[i] || !blink_on_r[i]) blink_time_r[i] <= 12'd0;
      end
    end
  end

  // wave lookup, blink scale, final color
  logic [8:0]  w_r, f, mix, f_inv;
  logic [16:0] sc_r;
  logic [17:0] sc_c;
  logic [7:0]  target;
  logic [24:0] scaled [3];

  assign f      = (floor_r > 9'd256) ? 9'd256 : floor_r;
  assign f_inv  = 9'd256 - f;
  assign mix    = 9'd256 - w_r;
  assign sc_c   = {1'b0, f, 8'h00} + ({9'd0, f_inv} * {9'd0, mix});
  assign target = lit ? 8'h00 : 8'hFF;

  always_comb begin
    for (int i = 0; i < 3; i++) scaled[i] = {17'd0, kept_r[i]} * {8'd0, sc_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.lut_load) w_r <= lpec_pkg::WAVE_LUT[quo_r];
    if (cmd.scale_load) sc_r <= sc_c[16:0];
    if (cmd.apply_load) begin
      for (int i = 0; i < 3; i++) begin
        case (eff)
          lpec_pkg::EFF_STROBE: shown_r[i] <= blend8(kept_r[i], target, w_r);
          lpec_pkg::EFF_BLINK: begin
            if (sc_r < lpec_pkg::BLINK_FULL_SCALE) shown_r[i] <= scaled[i][23:16];
            else shown_r[i] <= kept_r[i];
          end
          default: shown_r[i] <= kept_r[i];
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.shown_red   <= shown_r[0];
      out_item.shown_green <= shown_r[1];
      out_item.shown_blue  <= shown_r[2];
      out_item.kept_red    <= kept_r[0];
      out_item.kept_green  <= kept_r[1];
      out_item.kept_blue   <= kept_r[2];
    end
  end

endmodule

// ----- rtl/lpec_ctrl.sv -----
// Controller: sequences pixel, tick and set transactions over the datapath.
`timescale 1ns / 1ps
module lpec_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lpec_pkg::dp_stat_t stat,
  output lpec_pkg::dp_cmd_t  cmd
);

  lpec_pkg::state_t state_r, state_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  lpec_pkg::phase_t sel_r, sel_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpec_pkg::ST_IDLE;
      cnt_r       <= 5'd0;
      sel_r       <= lpec_pkg::PH_STROBE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.tick_sel = sel_r;
    case (state_r)
      lpec_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = lpec_pkg::ST_DECODE;
        end
      end
      lpec_pkg::ST_DECODE: begin
        case (stat.command)
          lpec_pkg::CMD_PIXEL: state_nxt = lpec_pkg::ST_BLEND;
          lpec_pkg::CMD_TICK: begin
            sel_nxt   = lpec_pkg::PH_STROBE;
            state_nxt = lpec_pkg::ST_TCHK;
          end
          lpec_pkg::CMD_SET: state_nxt = lpec_pkg::ST_SET;
          default: state_nxt = lpec_pkg::ST_IDLE;
        endcase
      end
      lpec_pkg::ST_BLEND: begin
        cmd.blend_load = 1'b1;
        state_nxt      = lpec_pkg::ST_EVAL;
      end
      lpec_pkg::ST_EVAL: begin
        if (stat.eff == lpec_pkg::EFF_NONE) state_nxt = lpec_pkg::ST_APPLY;
        else begin
          cmd.div_load = 1'b1;
          cnt_nxt      = 5'd0;
          state_nxt    = lpec_pkg::ST_PDIV;
        end
      end
      lpec_pkg::ST_PDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == lpec_pkg::PIX_DIV_LAST) state_nxt = lpec_pkg::ST_LUT;
      end
      lpec_pkg::ST_LUT: begin
        cmd.lut_load = 1'b1;
        state_nxt    = lpec_pkg::ST_SCALE;
      end
      lpec_pkg::ST_SCALE: begin
        cmd.scale_load = 1'b1;
        state_nxt      = lpec_pkg::ST_APPLY;
      end
      lpec_pkg::ST_APPLY: begin
        cmd.apply_load = 1'b1;
        state_nxt      = lpec_pkg::ST_OUT;
      end
      lpec_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = lpec_pkg::ST_IDLE;
        end
      end
      lpec_pkg::ST_TCHK: begin
        if (stat.tick_act[sel_r]) begin
          cmd.div_load = 1'b1;
          cmd.div_tick = 1'b1;
          cnt_nxt      = 5'd0;
          state_nxt    = lpec_pkg::ST_TDIV;
        end else if (sel_r == lpec_pkg::PH_RIGHT) state_nxt = lpec_pkg::ST_IDLE;
        else sel_nxt = lpec_pkg::phase_t'(sel_r + 2'd1);
      end
      lpec_pkg::ST_TDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == lpec_pkg::TICK_DIV_LAST) state_nxt = lpec_pkg::ST_TUPD;
      end
      lpec_pkg::ST_TUPD: begin
        cmd.tick_update = 1'b1;
        if (sel_r == lpec_pkg::PH_RIGHT) state_nxt = lpec_pkg::ST_IDLE;
        else begin
          sel_nxt   = lpec_pkg::phase_t'(sel_r + 2'd1);
          state_nxt = lpec_pkg::ST_TCHK;
        end
      end
      lpec_pkg::ST_SET: begin
        cmd.set_update = 1'b1;
        state_nxt      = lpec_pkg::ST_IDLE;
      end
      default: state_nxt = lpec_pkg::ST_IDLE;
    endcase

    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

endmodule

// ----- rtl/led_pixel_effect_compositor.sv -----
// Pixel: decode, blend, apply and output; with blink or strobe a 20-step restoring
// divider finds the wave step, and a wave lookup and a scale step follow before apply.
// Tick: each active phase runs 12 divider steps for the phase modulo, then an update.
// Set: loads the effect requests. One transaction is worked at a time; the output
// register frees the result side.
// Synchronous active-low reset restores register defaults and clears all effects.
`timescale 1ns / 1ps
module led_pixel_effect_compositor (
  input  logic        clk,
  input  logic        rst_n,
  lpec_in_if.sink     in_ch,
  lpec_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  lpec_pkg::in_item_t  in_item;
  lpec_pkg::out_item_t out_item;
  lpec_pkg::dp_cmd_t   cmd;
  lpec_pkg::dp_stat_t  stat;

  assign in_item.command        = in_ch.command;
  assign in_item.from_red       = in_ch.from_red;
  assign in_item.from_green     = in_ch.from_green;
  assign in_item.from_blue      = in_ch.from_blue;
  assign in_item.to_red         = in_ch.to_red;
  assign in_item.to_green       = in_ch.to_green;
  assign in_item.to_blue        = in_ch.to_blue;
  assign in_item.visual_column  = in_ch.visual_column;
  assign in_item.fade_progress  = in_ch.fade_progress;
  assign in_item.strobe_request = in_ch.strobe_request;
  assign in_item.blink_request  = in_ch.blink_request;

  assign out_ch.shown_red   = out_item.shown_red;
  assign out_ch.shown_green = out_item.shown_green;
  assign out_ch.shown_blue  = out_item.shown_blue;
  assign out_ch.kept_red    = out_item.kept_red;
  assign out_ch.kept_green  = out_item.kept_green;
  assign out_ch.kept_blue   = out_item.kept_blue;

  lpec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lpec_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item)
  );

endmodule
